>>> hdl/dq_pkg.sv
// Package for the double-ended queue.
// Holds the operation and status codes and the fixed payload widths.
// No dependencies.
package dq_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_REAR  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_REAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [OCC_W-1:0]         occ_t;

endpackage

>>> hdl/dq_if.sv
// Valid/ready channel interfaces of the double-ended queue.
// dq_req_if carries operations in and dq_rsp_if carries results out.
// Depends on dq_pkg.
interface dq_req_if;
	import dq_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	data_t   value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic    valid;
	logic    ready;
	data_t   popped_value;
	status_t status;
	occ_t    occupancy;

	modport source (output valid, popped_value, status, occupancy, input ready);
	modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

>>> hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on dq_pkg, dq_if (dq_req_if, dq_rsp_if) and dq_ram.
//
//   Channel | Direction | Payload                            | Per transfer
//   --------+-----------+------------------------------------+------------------
//   req     | in        | action, value                      | one operation
//   rsp     | out       | popped_value, status, occupancy    | one result
//
// A new operation can be taken every cycle while rsp is not stalling. Its result is
// loaded into the output register once the middle stage holds it and the output
// register is free, and transfers on rsp from there; the registered read of the
// slot memory is what the middle stage waits for.
// Reset clears the front index, the count and all valid flags; the slot memory
// is not cleared, since only slots written by an earlier push are ever read.
// A stall on rsp holds the result register and then the middle stage, and req
// is held off only while both are full.
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input logic   clk,
	input logic   arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Queue bookkeeping: the front element sits at front_q, the rear element
	// count_q - 1 places after it, wrapping modulo DEPTH.
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	logic [AW-1:0] front_n;
	logic [CW-1:0] count_n;
	logic          full;
	logic          empty;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW:0]   rear_sum;
	logic [AW:0]   last_sum;
	logic [CW-1:0] last_off;
	logic [AW-1:0] rear_pos;
	logic [AW-1:0] last_pos;

	// Memory access for the operation being accepted.
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	data_t         mem_rdata;
	status_t       status_n;

	logic accept;
	logic out_free;
	logic advance;

	// Middle stage: waits for the read data of a pop.
	logic    valid_s1;
	logic    pop_ok_s1;
	status_t status_s1;
	occ_t    occ_s1;

	// Result register, drives rsp.
	logic    out_valid_q;
	data_t   popped_q;
	status_t status_q;
	occ_t    occ_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// Neighbor indexes of the front, wrapping at DEPTH even when it is not a
	// power of two.
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	// The sums stay below twice DEPTH, so one compare and subtract wraps them.
	assign last_off = count_q - 1'b1;
	assign rear_sum = {1'b0, front_q} + (AW + 1)'(count_q);
	assign last_sum = {1'b0, front_q} + (AW + 1)'(last_off);
	assign rear_pos = (rear_sum >= (AW + 1)'(DEPTH)) ?
		AW'(rear_sum - (AW + 1)'(DEPTH)) : rear_sum[AW-1:0];
	assign last_pos = (last_sum >= (AW + 1)'(DEPTH)) ?
		AW'(last_sum - (AW + 1)'(DEPTH)) : last_sum[AW-1:0];

	// Handshake: the middle stage moves on when the result register is free or
	// being emptied, and a new request enters when the middle stage is empty or moves on.
	assign out_free  = !out_valid_q || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign accept    = req.valid && req.ready;

	always_comb begin
		front_n  = front_q;
		count_n  = count_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = front_q;
		status_n = ST_OK;
		case (req.action)
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = front_dec;
					front_n  = front_dec;
					count_n  = count_q + 1'b1;
				end
			end
			ACT_PUSH_REAR: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = rear_pos;
					count_n  = count_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					mem_addr = front_q;
					front_n  = front_inc;
					count_n  = count_q - 1'b1;
				end
			end
			ACT_POP_REAR: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					mem_addr = last_pos;
					count_n  = count_q - 1'b1;
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	// Each operation touches the memory at most once, at the edge of its request
	// transfer, so two operations never meet on the same slot in one cycle.
	// The read data stays put until the next request transfer, which cannot come
	// before the middle stage has passed it on.
	dq_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (accept && mem_we),
		.re   (accept && mem_re),
		.addr (mem_addr),
		.wdata(req.value),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_n;
				count_q <= count_n;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= accept && mem_re;
			status_s1 <= status_n;
			occ_s1    <= OCC_W'(count_n);
		end
		if (advance) begin
			popped_q <= pop_ok_s1 ? mem_rdata : '0;
			status_q <= status_s1;
			occ_q    <= occ_s1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.occupancy    = occ_q;

endmodule

>>> hdl/dq_ram.sv
// Single-port synchronous memory for the queue slots, with a registered read.
// Contents are not reset. Depends on dq_pkg for the data type.
module dq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  dq_pkg::data_t     wdata,
	output dq_pkg::data_t     rdata
);
	import dq_pkg::*;

	data_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> hdl/dq_checker.sv
// Port-level checks for the double-ended queue, attached by bind.
// Depends on dq_pkg and on the ports of double_ended_queue.
module dq_checker #(
	parameter int DEPTH = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input dq_pkg::data_t     popped_value,
	input dq_pkg::status_t   status,
	input dq_pkg::occ_t      occupancy
);
	import dq_pkg::*;

	// A result that has not been taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before transfer");

	// A rejected push leaves the queue exactly full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
		else $error("full status with wrong occupancy");

	// A pop on an empty queue leaves it empty and returns no value.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> occupancy == '0 && popped_value == '0)
		else $error("empty status with data or occupancy");

endmodule

bind double_ended_queue dq_checker #(
	.DEPTH(DEPTH)
) u_dq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.popped_value(rsp.popped_value),
	.status      (rsp.status),
	.occupancy   (rsp.occupancy)
);
